// File: src/ptce_pkg.sv
// ----------------------------------------------------------------------------
// ptce_pkg: shared types, constants and helpers
// Frame and command constants, configuration bundle, queue entry and the
// small arithmetic helpers used by the front and back of the tracking engine.
// ----------------------------------------------------------------------------
package ptce_pkg;

	// input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_GOAL = 1'b1;

	// reply framing
	localparam logic [7:0] FRAME_LIMIT = 8'd50;
	localparam logic [7:0] FRAME_LEN   = 8'd11;
	localparam logic [7:0] FRAME_FIRST = 8'd2;
	localparam logic [7:0] FRAME_LAST  = 8'd9;
	localparam logic [7:0] TERMINATOR  = 8'hFF;

	// speed clamp
	localparam logic [3:0] MAX_SPEED = 4'd8;

	// drive command bytes
	localparam logic [7:0] CMD_HEAD     = 8'h80;
	localparam logic [7:0] CMD_COMMAND  = 8'h01;
	localparam logic [7:0] CMD_PAN_TILT = 8'h06;
	localparam logic [7:0] CMD_DRIVE    = 8'h01;
	localparam logic [7:0] DIR_POS      = 8'h02;
	localparam logic [7:0] DIR_NEG      = 8'h01;
	localparam logic [7:0] DIR_STOP     = 8'h03;

	// command byte positions
	localparam logic [3:0] BYTE_HEAD    = 4'd0;
	localparam logic [3:0] BYTE_COMMAND = 4'd1;
	localparam logic [3:0] BYTE_PT      = 4'd2;
	localparam logic [3:0] BYTE_DRIVE   = 4'd3;
	localparam logic [3:0] BYTE_PAN_SPD = 4'd4;
	localparam logic [3:0] BYTE_TLT_SPD = 4'd5;
	localparam logic [3:0] BYTE_PAN_DIR = 4'd6;
	localparam logic [3:0] BYTE_TLT_DIR = 4'd7;
	localparam logic [3:0] BYTE_LAST    = 4'd8;

	// register indexes
	localparam logic [2:0] REG_ADDRESS     = 3'd0;
	localparam logic [2:0] REG_PAN_OFFSET  = 3'd1;
	localparam logic [2:0] REG_TILT_OFFSET = 3'd2;
	localparam logic [2:0] REG_GAIN        = 3'd3;
	localparam logic [2:0] REG_DEADBAND    = 3'd4;

	typedef struct packed {
		logic [2:0]         camera_address;
		logic signed [10:0] pan_offset;
		logic signed [10:0] tilt_offset;
		logic [15:0]        speed_gain;
		logic [7:0]         deadband;
	} ptce_cfg_t;

	// one decoded frame: signed distance to the goal per axis
	typedef struct packed {
		logic signed [18:0] pan_err;
		logic signed [18:0] tilt_err;
	} ptce_frame_t;

	function automatic logic [17:0] err_mag(input logic signed [18:0] e);
		logic signed [18:0] n;
		n = -e;
		return e[18] ? n[17:0] : e[17:0];
	endfunction

	// product is |error| * gain; quotient is product >> 16
	function automatic logic signed [4:0] axis_speed(input logic [33:0] prod,
			input logic neg, input logic dead);
		logic [17:0] q;
		logic [3:0]  m;
		logic [4:0]  s;
		q = prod[33:16];
		m = (q >= {14'd0, MAX_SPEED}) ? MAX_SPEED : (q[3:0] + 4'd1);
		s = {1'b0, m};
		if (dead)
			return 5'sd0;
		return neg ? -$signed(s) : $signed(s);
	endfunction

	function automatic logic [7:0] speed_mag(input logic signed [4:0] s);
		logic signed [4:0] n;
		n = -s;
		return {4'd0, s[4] ? n[3:0] : s[3:0]};
	endfunction

	function automatic logic [7:0] dir_code(input logic signed [4:0] s);
		if (s > 5'sd0)
			return DIR_POS;
		if (s < 5'sd0)
			return DIR_NEG;
		return DIR_STOP;
	endfunction

endpackage

// File: src/ptce_front.sv
// ----------------------------------------------------------------------------
// ptce_front: input side of the tracking engine
// Collects reply bytes into a frame, keeps the pan and tilt goals, and pushes
// the per-axis position error of every complete position frame to the queue.
// ----------------------------------------------------------------------------
module ptce_front
	import ptce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [7:0]         in_byte,
	input  logic signed [15:0] target_pan,
	input  logic signed [15:0] target_tilt,
	input  ptce_cfg_t          cfg,
	input  logic               q_full,
	output logic               q_push,
	output ptce_frame_t        q_data
);

	logic               accept;
	logic [7:0]         fill_q;
	logic [7:0]         fill_base;
	logic [7:0]         fill_next;
	logic [7:0]         fill_off;
	logic               store_en;
	logic [7:0]         store_q [8];
	logic signed [17:0] pan_goal_q;
	logic signed [17:0] tilt_goal_q;
	logic signed [15:0] pan_pos;
	logic signed [15:0] tilt_pos;
	logic               frame_end;
	logic               frame_full;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	always_comb begin
		fill_base  = (fill_q >= FRAME_LIMIT) ? 8'd0 : fill_q;
		fill_next  = fill_base + 8'd1;
		fill_off   = fill_base - FRAME_FIRST;
		store_en   = (fill_base >= FRAME_FIRST) && (fill_base <= FRAME_LAST);
		frame_end  = (in_byte == TERMINATOR);
		frame_full = (fill_next == FRAME_LEN);
	end

	assign pan_pos  = {store_q[0][3:0], store_q[1][3:0], store_q[2][3:0], store_q[3][3:0]};
	assign tilt_pos = {store_q[4][3:0], store_q[5][3:0], store_q[6][3:0], store_q[7][3:0]};

	assign q_data.pan_err  = {pan_goal_q[17], pan_goal_q} - {{3{pan_pos[15]}}, pan_pos};
	assign q_data.tilt_err = {{3{tilt_pos[15]}}, tilt_pos} - {tilt_goal_q[17], tilt_goal_q};
	assign q_push          = accept & (operation == OP_BYTE) & frame_end & frame_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pan_goal_q  <= '0;
			tilt_goal_q <= '0;
		end else if (accept) begin
			if (operation == OP_GOAL) begin
				pan_goal_q  <= {{2{target_pan[15]}}, target_pan}
					+ {{7{cfg.pan_offset[10]}}, cfg.pan_offset};
				tilt_goal_q <= {{2{target_tilt[15]}}, target_tilt}
					+ {{7{cfg.tilt_offset[10]}}, cfg.tilt_offset};
			end else begin
				// terminator closes any frame
				fill_q <= frame_end ? 8'd0 : fill_next;
			end
		end
	end

	// position nibbles; no reset, every entry is written before it is decoded
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_BYTE) && store_en)
			store_q[fill_off[2:0]] <= in_byte;
	end

endmodule

// File: src/ptce_queue.sv
// ----------------------------------------------------------------------------
// ptce_queue: two-entry frame queue
// Decouples frame collection from command generation so that either side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module ptce_queue
	import ptce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ptce_frame_t push_data,
	output logic        full,
	output logic        valid,
	input  logic        pop,
	output ptce_frame_t pop_data
);

	ptce_frame_t entry_q [2];
	logic [1:0]  count_q;
	logic        wr_q;
	logic        rd_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("frame queue written while full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("frame queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_q == rd_q))
		else $error("frame queue pointers disagree with count");

endmodule

// File: src/ptce_back.sv
// ----------------------------------------------------------------------------
// ptce_back: speed computation and drive command generation
// Takes one frame error pair from the queue, scales it into axis speeds and,
// when a speed changed, sends the nine-byte drive command.
// ----------------------------------------------------------------------------
module ptce_back
	import ptce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ptce_cfg_t   cfg,
	input  logic        q_valid,
	input  ptce_frame_t q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        moving
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL   = 4'b0010,
		ST_SPEED = 4'b0100,
		ST_EMIT  = 4'b1000
	} back_state_t;

	back_state_t        state_q;
	logic [17:0]        pan_mag_s1;
	logic [17:0]        tilt_mag_s1;
	logic               pan_neg_s1;
	logic               tilt_neg_s1;
	logic               pan_dead_s1;
	logic               tilt_dead_s1;
	logic [33:0]        pan_prod_s2;
	logic [33:0]        tilt_prod_s2;
	logic signed [4:0]  pan_spd_q;
	logic signed [4:0]  tilt_spd_q;
	logic signed [4:0]  pan_new;
	logic signed [4:0]  tilt_new;
	logic               moving_q;
	logic [3:0]         idx_q;
	logic               transfer;
	logic               last_xfer;
	logic [17:0]        pan_mag;
	logic [17:0]        tilt_mag;

	assign out_valid = (state_q == ST_EMIT);
	assign transfer  = out_valid & ~out_stall;
	assign last      = (idx_q == BYTE_LAST);
	assign last_xfer = transfer & last;
	assign moving    = moving_q;
	assign q_pop     = q_valid & ((state_q == ST_IDLE) | last_xfer);

	assign pan_mag  = err_mag(q_data.pan_err);
	assign tilt_mag = err_mag(q_data.tilt_err);
	assign pan_new  = axis_speed(pan_prod_s2, pan_neg_s1, pan_dead_s1);
	assign tilt_new = axis_speed(tilt_prod_s2, tilt_neg_s1, tilt_dead_s1);

	always_comb begin
		unique case (idx_q)
			BYTE_HEAD:    out_byte = CMD_HEAD + {5'd0, cfg.camera_address};
			BYTE_COMMAND: out_byte = CMD_COMMAND;
			BYTE_PT:      out_byte = CMD_PAN_TILT;
			BYTE_DRIVE:   out_byte = CMD_DRIVE;
			BYTE_PAN_SPD: out_byte = speed_mag(pan_spd_q);
			BYTE_TLT_SPD: out_byte = speed_mag(tilt_spd_q);
			BYTE_PAN_DIR: out_byte = dir_code(pan_spd_q);
			BYTE_TLT_DIR: out_byte = dir_code(tilt_spd_q);
			default:      out_byte = TERMINATOR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pan_spd_q  <= '0;
			tilt_spd_q <= '0;
			moving_q   <= 1'b1;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SPEED;
				end
				ST_SPEED: begin
					if (pan_new == pan_spd_q && tilt_new == tilt_spd_q) begin
						state_q <= ST_IDLE;
					end else begin
						pan_spd_q  <= pan_new;
						tilt_spd_q <= tilt_new;
						moving_q   <= (pan_new != 5'sd0) || (tilt_new != 5'sd0);
						idx_q      <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (transfer)
						idx_q <= idx_q + 4'd1;
					// go straight to the next frame if one waits
					if (last_xfer)
						state_q <= q_valid ? ST_MUL : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pan_mag_s1   <= pan_mag;
			tilt_mag_s1  <= tilt_mag;
			pan_neg_s1   <= q_data.pan_err[18];
			tilt_neg_s1  <= q_data.tilt_err[18];
			pan_dead_s1  <= (pan_mag < {10'd0, cfg.deadband});
			tilt_dead_s1 <= (tilt_mag < {10'd0, cfg.deadband});
		end
		if (state_q == ST_MUL) begin
			pan_prod_s2  <= pan_mag_s1 * cfg.speed_gain;
			tilt_prod_s2 <= tilt_mag_s1 * cfg.speed_gain;
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("frame taken from empty queue");

	a_last_term: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (out_byte == TERMINATOR))
		else $error("final command byte is not the terminator");

	a_stop_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !moving && (idx_q == BYTE_PAN_SPD || idx_q == BYTE_TLT_SPD))
		|-> (out_byte == 8'd0))
		else $error("stop command carries a nonzero speed");

	a_emit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(transfer && !last) |=> (out_valid && idx_q == $past(idx_q) + 4'd1))
		else $error("command byte index did not advance on transfer");

endmodule

// File: src/pan_tilt_tracking_command_engine_unit.sv
// ----------------------------------------------------------------------------
// pan_tilt_tracking_command_engine_unit: camera pan/tilt tracking engine
// Decodes camera position replies and issues drive commands toward a goal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): operation 0 carries one reply byte in
//   in_byte, operation 1 sets a new pan/tilt goal from target_pan and
//   target_tilt plus the offset registers. One item transfers per cycle while in_stall is low.
//   Output channel (out_valid/out_stall): a nine-byte drive command, one byte
//   per transfer, last marks the final byte, moving is low for a stop command.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects the
//   register, cfg_data carries its value in the low bits. Write only when idle.
// Flow:
//   After the terminator of an 11-byte position frame transfers, the frame
//   is queued, popped in idle, scaled in the multiply and compare states and
//   its first command byte offered if a speed changed; after the last of its
//   nine bytes the command unit goes straight to the next waiting frame.
// Reset clears the frame count, goals, previous speeds and the queue;
// registers return to their defaults. While out_stall is high the current
// byte holds; finished frames wait in a two-entry queue and in_stall rises
// only when that queue is full.
// ----------------------------------------------------------------------------
module pan_tilt_tracking_command_engine_unit
	import ptce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [7:0]         in_byte,
	input  logic signed [15:0] target_pan,
	input  logic signed [15:0] target_tilt,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               moving,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	ptce_cfg_t   cfg_q;
	logic        q_full;
	logic        q_push;
	logic        q_valid;
	logic        q_pop;
	ptce_frame_t push_data;
	ptce_frame_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_address <= 3'd1;
			cfg_q.pan_offset     <= '0;
			cfg_q.tilt_offset    <= '0;
			cfg_q.speed_gain     <= 16'd983;
			cfg_q.deadband       <= 8'd7;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ADDRESS:     cfg_q.camera_address <= cfg_data[2:0];
				REG_PAN_OFFSET:  cfg_q.pan_offset     <= cfg_data[10:0];
				REG_TILT_OFFSET: cfg_q.tilt_offset    <= cfg_data[10:0];
				REG_GAIN:        cfg_q.speed_gain     <= cfg_data;
				REG_DEADBAND:    cfg_q.deadband       <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	ptce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.in_byte     (in_byte),
		.target_pan  (target_pan),
		.target_tilt (target_tilt),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (push_data)
	);

	ptce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (pop_data)
	);

	ptce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.moving    (moving)
	);

endmodule
